### src/dfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal result frame parser package
// Shared types, character codes, field indexes and the frame tag table.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int FIELD_COUNT_DEF = 16;
    localparam int FRAME_CAP_DEF   = 512;

    localparam int BYTE_COUNT_W = 10;
    localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_MAX = 10'd1023;
    localparam logic [BYTE_COUNT_W-1:0] TAG_LEN        = 10'd8;
    // A frame shorter than ten bytes is rejected, so the last position must be nine or more.
    localparam logic [BYTE_COUNT_W-1:0] MIN_LAST_POS   = 10'd9;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int FIELD_LANE   = 0;
    localparam int FIELD_INVOC  = 1;
    localparam int FIELD_STATUS = 2;
    localparam int FIELD_CODE   = 12;

    localparam logic [63:0] STATUS_MAX = 64'd7;
    localparam logic [63:0] CODE_MAX   = 64'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_last;
        logic [1:0]  expected_lane;
        logic [62:0] expected_invocation;
    } t_byte_in;

    typedef struct packed {
        logic        field_strobe;
        logic [3:0]  field_number;
        logic [63:0] field_value;
        logic        frame_done;
        logic        frame_ok;
    } t_result;

    // Expected byte of the "HALRES1|" tag at each of its eight positions.
    function automatic logic [7:0] tag_byte(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = 8'h48;
            3'd1: ch = 8'h41;
            3'd2: ch = 8'h4C;
            3'd3: ch = 8'h52;
            3'd4: ch = 8'h45;
            3'd5: ch = 8'h53;
            3'd6: ch = 8'h31;
            3'd7: ch = 8'h7C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### src/decimal_result_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal result frame parser core
// Parses a "HALRES1|" result frame byte by byte and reports field values and
// a per-frame verdict.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, every cycle, for as long as results are
// taken. Each byte passes an input register, then the parse step (a single
// multiply-by-ten accumulate and the field checks) writes its result, if it
// has one, into the output register when that register is free, and the
// result transaction is taken from there. A byte that closes a field or ends
// the frame gives one transaction on the output; other bytes give none. While
// the output is stalled one further byte is held in the input register before
// o_stall rises.
module decimal_result_frame_parser_core import dfp_pkg::*; #(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF,
    parameter int FRAME_CAP   = FRAME_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_last,
    input  logic [1:0]         i_expected_lane,
    input  logic [62:0]        i_expected_invocation,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_field_strobe,
    output logic [3:0]         o_field_number,
    output logic signed [63:0] o_field_value,
    output logic               o_frame_done,
    output logic               o_frame_ok
);

    logic     r_in_valid;
    t_byte_in r_in;
    logic     r_out_valid;
    t_result  r_out;

    logic     out_free;
    logic     step;
    logic     accept;
    logic     has_result;
    t_result  result;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.data_byte           <= i_data_byte;
            r_in.frame_last          <= i_frame_last;
            r_in.expected_lane       <= i_expected_lane;
            r_in.expected_invocation <= i_expected_invocation;
        end
    end

    dfp_parser #(
        .FIELD_COUNT (FIELD_COUNT),
        .FRAME_CAP   (FRAME_CAP)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_field_strobe = r_out.field_strobe;
    assign o_field_number = r_out.field_number;
    assign o_field_value  = r_out.field_value;
    assign o_frame_done   = r_out.frame_done;
    assign o_frame_ok     = r_out.frame_ok;

    a_result_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_field_strobe || o_frame_done))
        else $error("output transaction carries neither a field nor a verdict");

endmodule

### src/dfp_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator datapath
// Multiply-by-ten accumulate with overflow detect, range limit check and
// two's complement value of the field being parsed.
// ----------------------------------------------------------------------------
module dfp_accum import dfp_pkg::*; (
    input  logic [63:0] i_magnitude,
    input  logic        i_minus,
    input  logic [3:0]  i_digit,
    output logic [63:0] o_next_magnitude,
    output logic        o_overflow,
    output logic        o_over_limit,
    output logic [63:0] o_value
);

    logic [67:0] sum;

    // Ten times the magnitude is built from two shifts, then the digit is added.
    assign sum = {1'b0, i_magnitude, 3'b000} + {3'b000, i_magnitude, 1'b0}
               + {64'd0, i_digit};

    assign o_next_magnitude = sum[63:0];
    assign o_overflow       = |sum[67:64];

    // A negative field may reach 2^63, a positive one only 2^63 - 1.
    assign o_over_limit = i_minus ? (i_magnitude[63] && |i_magnitude[62:0])
                                  : i_magnitude[63];

    assign o_value = i_minus ? (64'd0 - i_magnitude) : i_magnitude;

endmodule

### src/dfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser state and per-byte decision
// Holds the per-frame state and decides, for one byte, the next state and
// the result item that the byte causes.
// ----------------------------------------------------------------------------
module dfp_parser import dfp_pkg::*; #(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF,
    parameter int FRAME_CAP   = FRAME_CAP_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_byte_in i_byte,
    output logic     o_has_result,
    output t_result  o_result
);

    localparam int FC_W = $clog2(FIELD_COUNT + 1);
    localparam logic [FC_W-1:0] LAST_FIELD = FC_W'(FIELD_COUNT - 1);
    localparam logic [FC_W-1:0] ALL_FIELDS = FC_W'(FIELD_COUNT);
    localparam logic [BYTE_COUNT_W-1:0] CAP_POS = BYTE_COUNT_W'(FRAME_CAP - 1);

    logic [BYTE_COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [FC_W-1:0]         r_field_count, n_field_count;
    logic [63:0]             r_magnitude, n_magnitude;
    logic                    r_minus_seen, n_minus_seen;
    logic                    r_digit_nz, n_digit_nz;
    logic                    r_at_start, n_at_start;
    logic                    r_error, n_error;
    logic                    r_fields_closed, n_fields_closed;
    logic                    r_value_bad, n_value_bad;

    logic [63:0] next_magnitude;
    logic        overflow;
    logic        over_limit;
    logic [63:0] value;
    logic [7:0]  b;
    logic        final_field;
    logic        strobe;

    assign b = i_byte.data_byte;

    dfp_accum u_accum (
        .i_magnitude      (r_magnitude),
        .i_minus          (r_minus_seen),
        .i_digit          (4'(b - CH_ZERO)),
        .o_next_magnitude (next_magnitude),
        .o_overflow       (overflow),
        .o_over_limit     (over_limit),
        .o_value          (value)
    );

    assign final_field = (r_field_count >= LAST_FIELD);

    always_comb begin
        n_byte_count    = (r_byte_count == BYTE_COUNT_MAX) ? r_byte_count
                                                           : r_byte_count + BYTE_COUNT_W'(1);
        n_field_count   = r_field_count;
        n_magnitude     = r_magnitude;
        n_minus_seen    = r_minus_seen;
        n_digit_nz      = r_digit_nz;
        n_at_start      = r_at_start;
        n_error         = r_error || (r_byte_count >= CAP_POS);
        n_fields_closed = r_fields_closed;
        n_value_bad     = r_value_bad;
        strobe          = 1'b0;

        if (!n_error) begin
            if (r_byte_count < TAG_LEN) begin
                if (b != tag_byte(r_byte_count[2:0])) begin
                    n_error = 1'b1;
                end
            end else if (r_fields_closed) begin
                n_error = 1'b1;
            end else if (b == CH_MINUS && r_at_start) begin
                n_minus_seen = 1'b1;
                n_at_start   = 1'b0;
            end else if (b == CH_BAR || b == CH_NL) begin
                if (!r_digit_nz || over_limit) begin
                    n_error = 1'b1;
                end else if (final_field ? (b != CH_NL) : (b != CH_BAR)) begin
                    n_error = 1'b1;
                end else begin
                    strobe = 1'b1;
                    if (r_field_count == FC_W'(FIELD_LANE)
                        && value != {62'd0, i_byte.expected_lane}) begin
                        n_value_bad = 1'b1;
                    end
                    if (r_field_count == FC_W'(FIELD_INVOC)
                        && value != {1'b0, i_byte.expected_invocation}) begin
                        n_value_bad = 1'b1;
                    end
                    if (r_field_count == FC_W'(FIELD_STATUS) && value > STATUS_MAX) begin
                        n_value_bad = 1'b1;
                    end
                    if (r_field_count == FC_W'(FIELD_CODE) && value > CODE_MAX) begin
                        n_value_bad = 1'b1;
                    end
                    n_field_count = r_field_count + FC_W'(1);
                    if (final_field) begin
                        n_fields_closed = 1'b1;
                    end
                    n_magnitude  = 64'd0;
                    n_minus_seen = 1'b0;
                    n_digit_nz   = 1'b0;
                    n_at_start   = 1'b1;
                end
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                if (overflow) begin
                    n_error = 1'b1;
                end else begin
                    n_magnitude = next_magnitude;
                    n_digit_nz  = 1'b1;
                    n_at_start  = 1'b0;
                end
            end else begin
                n_error = 1'b1;
            end
        end

        o_has_result          = strobe || i_byte.frame_last;
        o_result.field_strobe = strobe;
        o_result.field_number = strobe ? 4'(r_field_count) : 4'd0;
        o_result.field_value  = strobe ? value : 64'd0;
        o_result.frame_done   = i_byte.frame_last;
        o_result.frame_ok     = i_byte.frame_last && !n_error && n_fields_closed
                                && !n_value_bad && (r_byte_count >= MIN_LAST_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_field_count   <= '0;
            r_magnitude     <= '0;
            r_minus_seen    <= 1'b0;
            r_digit_nz      <= 1'b0;
            r_at_start      <= 1'b1;
            r_error         <= 1'b0;
            r_fields_closed <= 1'b0;
            r_value_bad     <= 1'b0;
        end else if (i_step) begin
            if (i_byte.frame_last) begin
                // The last byte of a frame returns all per-frame state to reset.
                r_byte_count    <= '0;
                r_field_count   <= '0;
                r_magnitude     <= '0;
                r_minus_seen    <= 1'b0;
                r_digit_nz      <= 1'b0;
                r_at_start      <= 1'b1;
                r_error         <= 1'b0;
                r_fields_closed <= 1'b0;
                r_value_bad     <= 1'b0;
            end else begin
                r_byte_count    <= n_byte_count;
                r_field_count   <= n_field_count;
                r_magnitude     <= n_magnitude;
                r_minus_seen    <= n_minus_seen;
                r_digit_nz      <= n_digit_nz;
                r_at_start      <= n_at_start;
                r_error         <= n_error;
                r_fields_closed <= n_fields_closed;
                r_value_bad     <= n_value_bad;
            end
        end
    end

    a_field_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_count <= ALL_FIELDS)
        else $error("field count ran past the number of fields");

    a_closed_means_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fields_closed |-> (r_field_count == ALL_FIELDS))
        else $error("fields closed flag set before every field closed");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte.frame_last) |=> (r_byte_count == '0 && !r_error))
        else $error("frame state not cleared after the last byte");

endmodule

### verif/dfp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the decimal result frame parser
// Watches both channels and keeps its own model of the frame parser. It
// forms the expected field and verdict transactions from each accepted
// byte and compares every output transaction with the oldest one waiting.
// ----------------------------------------------------------------------------
module dfp_result_checker import dfp_pkg::*; #(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF,
    parameter int FRAME_CAP   = FRAME_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_last,
    input  logic [1:0]         i_expected_lane,
    input  logic [62:0]        i_expected_invocation,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_field_strobe,
    input  logic [3:0]         i_field_number,
    input  logic signed [63:0] i_field_value,
    input  logic               i_frame_done,
    input  logic               i_frame_ok,
    output int                 o_mismatch_count,
    output int                 o_pending_count
);

    localparam logic [63:0] FRAME_TAG     = "HALRES1|";
    localparam logic [63:0] POS_MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAG_MAX   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ACCUM_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          MIN_FRAME_LEN = 10;
    localparam int          REPORT_LIMIT  = 50;

    // Parser state, cleared by reset and at the end of every frame.
    logic [9:0]  byte_pos;
    logic [4:0]  field_idx;
    logic [63:0] accum;
    logic        neg_sign;
    logic        has_digit;
    logic        at_start;
    logic        frame_err;
    logic        last_closed;
    logic        check_failed;

    t_result awaited_results[$];
    int      mismatch_total = 0;

    assign o_mismatch_count = mismatch_total;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_total < REPORT_LIMIT) begin
            $display("%0t ns: %s mismatch, got 0x%h, expected 0x%h",
                     $time, what, got, want);
        end
        mismatch_total++;
    endtask

    function automatic void clear_parser();
        byte_pos     = '0;
        field_idx    = '0;
        accum        = '0;
        neg_sign     = 1'b0;
        has_digit    = 1'b0;
        at_start     = 1'b1;
        frame_err    = 1'b0;
        last_closed  = 1'b0;
        check_failed = 1'b0;
    endfunction

    task automatic predict_frame_byte(input t_byte_in b, output logic produced,
                                      output t_result r);
        logic [9:0]  pos;
        logic [10:0] frame_len;
        logic [63:0] limit;
        logic [63:0] value;
        logic [63:0] digit;
        logic        final_field;
        logic        strobe;
        logic [4:0]  closed_idx;
        logic [63:0] closed_val;

        pos        = byte_pos;
        strobe     = 1'b0;
        closed_idx = '0;
        closed_val = '0;
        if (pos >= FRAME_CAP - 1) frame_err = 1'b1;
        frame_len = {1'b0, pos} + 11'd1;
        if (byte_pos != BYTE_COUNT_MAX) byte_pos = byte_pos + 10'd1;

        if (!frame_err) begin
            if (pos < TAG_LEN) begin
                if (b.data_byte != FRAME_TAG[63 - 8 * pos[2:0] -: 8]) frame_err = 1'b1;
            end else if (last_closed) begin
                frame_err = 1'b1;
            end else if (b.data_byte == CH_MINUS && at_start) begin
                neg_sign = 1'b1;
                at_start = 1'b0;
            end else if (b.data_byte == CH_BAR || b.data_byte == CH_NL) begin
                limit       = neg_sign ? NEG_MAG_MAX : POS_MAG_MAX;
                final_field = (int'(field_idx) + 1 >= FIELD_COUNT);
                if (!has_digit || accum > limit) begin
                    frame_err = 1'b1;
                end else if (final_field ? (b.data_byte != CH_NL)
                                         : (b.data_byte != CH_BAR)) begin
                    frame_err = 1'b1;
                end else begin
                    value      = neg_sign ? (64'd0 - accum) : accum;
                    strobe     = 1'b1;
                    closed_idx = field_idx;
                    closed_val = value;
                    // A failed value check only spoils the verdict; parsing goes on.
                    if (field_idx == FIELD_LANE && value != {62'd0, b.expected_lane})
                        check_failed = 1'b1;
                    if (field_idx == FIELD_INVOC && value != {1'b0, b.expected_invocation})
                        check_failed = 1'b1;
                    if (field_idx == FIELD_STATUS && value > STATUS_MAX)
                        check_failed = 1'b1;
                    if (field_idx == FIELD_CODE && value > CODE_MAX)
                        check_failed = 1'b1;
                    field_idx = field_idx + 5'd1;
                    if (final_field) last_closed = 1'b1;
                    accum     = '0;
                    neg_sign  = 1'b0;
                    has_digit = 1'b0;
                    at_start  = 1'b1;
                end
            end else if (b.data_byte >= CH_ZERO && b.data_byte <= CH_NINE) begin
                digit = {56'd0, b.data_byte - CH_ZERO};
                if (accum > (ACCUM_MAX - digit) / 64'd10) begin
                    frame_err = 1'b1;
                end else begin
                    accum     = accum * 64'd10 + digit;
                    has_digit = 1'b1;
                    at_start  = 1'b0;
                end
            end else begin
                frame_err = 1'b1;
            end
        end

        produced       = strobe || b.frame_last;
        r.field_strobe = strobe;
        r.field_number = closed_idx[3:0];
        r.field_value  = closed_val;
        r.frame_done   = b.frame_last;
        r.frame_ok     = b.frame_last && !frame_err && last_closed && !check_failed
                         && frame_len >= MIN_FRAME_LEN;
        if (b.frame_last) clear_parser();
    endtask

    always @(posedge i_clk) begin : monitor
        t_byte_in taken;
        t_result  got;
        t_result  want;
        logic     produced;

        if (!i_rst_n) begin
            clear_parser();
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.field_strobe = i_field_strobe;
                got.field_number = i_field_number;
                got.field_value  = i_field_value;
                got.frame_done   = i_frame_done;
                got.frame_ok     = i_frame_ok;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected transaction", got.field_value, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.field_strobe !== want.field_strobe)
                        report_mismatch("field_strobe", 64'(got.field_strobe),
                                        64'(want.field_strobe));
                    if (got.field_number !== want.field_number)
                        report_mismatch("field_number", 64'(got.field_number),
                                        64'(want.field_number));
                    if (got.field_value !== want.field_value)
                        report_mismatch("field_value", got.field_value, want.field_value);
                    if (got.frame_done !== want.frame_done)
                        report_mismatch("frame_done", 64'(got.frame_done),
                                        64'(want.frame_done));
                    if (got.frame_ok !== want.frame_ok)
                        report_mismatch("frame_ok", 64'(got.frame_ok), 64'(want.frame_ok));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                taken.data_byte           = i_data_byte;
                taken.frame_last          = i_frame_last;
                taken.expected_lane       = i_expected_lane;
                taken.expected_invocation = i_expected_invocation;
                predict_frame_byte(taken, produced, want);
                if (produced) awaited_results.push_back(want);
            end
        end
        o_pending_count <= awaited_results.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the decimal result frame parser core
// Feeds well-formed and damaged result frames byte by byte with random
// gaps and output stalls; the result checker predicts and compares every
// field and verdict transaction.
// ----------------------------------------------------------------------------
module tb;
    import dfp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 600;
    localparam int NUM_FIELDS   = FIELD_COUNT_DEF;
    localparam int TAG_BYTES    = 8;
    localparam int HUGE_FRAME   = 1100;

    typedef enum int {
        FLAW_NONE, FLAW_BYTE, FLAW_CUT, FLAW_TRAIL, FLAW_TERM, FLAW_EMPTY,
        FLAW_MINUS, FLAW_CHAR, FLAW_OVERFLOW, FLAW_CHECK, FLAW_NOISE
    } flaw_e;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_data_byte;
    logic               i_frame_last;
    logic [1:0]         i_expected_lane;
    logic [62:0]        i_expected_invocation;
    logic               o_valid;
    logic               i_stall;
    logic               o_field_strobe;
    logic [3:0]         o_field_number;
    logic signed [63:0] o_field_value;
    logic               o_frame_done;
    logic               o_frame_ok;

    int mismatch_count;
    int pending_count;
    int cycle_count;
    int bytes_sent = 0;
    bit idle_on = 1'b0;

    // Frame under construction and the per-field content it is built from.
    logic [7:0]  frame_bytes[$];
    logic [63:0] field_vals[NUM_FIELDS];
    int          field_zeros[NUM_FIELDS];
    bit          use_text[NUM_FIELDS];
    string       field_text[NUM_FIELDS];
    logic [1:0]  cur_lane;
    logic [62:0] cur_invoc;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    decimal_result_frame_parser_core #(
        .FIELD_COUNT (FIELD_COUNT_DEF),
        .FRAME_CAP   (FRAME_CAP_DEF)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_data_byte           (i_data_byte),
        .i_frame_last          (i_frame_last),
        .i_expected_lane       (i_expected_lane),
        .i_expected_invocation (i_expected_invocation),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_field_strobe        (o_field_strobe),
        .o_field_number        (o_field_number),
        .o_field_value         (o_field_value),
        .o_frame_done          (o_frame_done),
        .o_frame_ok            (o_frame_ok)
    );

    dfp_result_checker #(
        .FIELD_COUNT (FIELD_COUNT_DEF),
        .FRAME_CAP   (FRAME_CAP_DEF)
    ) result_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_valid),
        .i_in_stall            (o_stall),
        .i_data_byte           (i_data_byte),
        .i_frame_last          (i_frame_last),
        .i_expected_lane       (i_expected_lane),
        .i_expected_invocation (i_expected_invocation),
        .i_out_valid           (o_valid),
        .i_out_stall           (i_stall),
        .i_field_strobe        (o_field_strobe),
        .i_field_number        (o_field_number),
        .i_field_value         (o_field_value),
        .i_frame_done          (o_frame_done),
        .i_frame_ok            (o_frame_ok),
        .o_mismatch_count      (mismatch_count),
        .o_pending_count       (pending_count)
    );

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    endfunction

    function automatic void push_number(input logic [63:0] v, input int zeros);
        logic [63:0] mag;
        logic [63:0] rem;
        logic [7:0]  digits[$];

        mag = v[63] ? (64'd0 - v) : v;
        if (v[63]) frame_bytes.push_back(CH_MINUS);
        repeat (zeros) frame_bytes.push_back(CH_ZERO);
        do begin
            rem = mag % 64'd10;
            digits.push_front(CH_ZERO + rem[7:0]);
            mag = mag / 64'd10;
        end while (mag != 0);
        foreach (digits[i]) frame_bytes.push_back(digits[i]);
    endfunction

    function automatic void build_frame();
        frame_bytes.delete();
        push_text("HALRES1|");
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (use_text[f]) push_text(field_text[f]);
            else push_number(field_vals[f], field_zeros[f]);
            frame_bytes.push_back(f == NUM_FIELDS - 1 ? CH_NL : CH_BAR);
        end
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] r;

        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return r % 64'd1000;
            4:          return 64'd0 - (r % 64'd100);
            5:          return r;
            6: begin
                case ($urandom_range(0, 2))
                    0:       return 64'h7FFF_FFFF_FFFF_FFFF;
                    1:       return 64'h8000_0000_0000_0000;
                    default: return 64'd0;
                endcase
            end
            7:          return r >> $urandom_range(1, 63);
            8:          return 64'd0 - (r >> $urandom_range(1, 63));
            default:    return r % 64'd10;
        endcase
    endfunction

    // New identity for the frame and field contents that pass every check.
    function automatic void fresh_frame();
        logic [63:0] r;

        r         = {$urandom, $urandom};
        cur_lane  = 2'($urandom_range(0, 2));
        cur_invoc = (r[62:0] == 63'd0) ? 63'd1 : r[62:0];
        for (int f = 0; f < NUM_FIELDS; f++) begin
            field_vals[f]  = pick_value();
            field_zeros[f] = 0;
            use_text[f]    = 1'b0;
            field_text[f]  = "";
        end
        field_vals[FIELD_LANE]   = {62'd0, cur_lane};
        field_vals[FIELD_INVOC]  = {1'b0, cur_invoc};
        field_vals[FIELD_STATUS] = 64'($urandom_range(0, 7));
        field_vals[FIELD_CODE]   = 64'($urandom_range(0, 4));
    endfunction

    function automatic void break_value_check(input int which);
        case (which)
            0: field_vals[FIELD_LANE] = (cur_lane == 2'd2) ? 64'd0 : {62'd0, cur_lane + 2'd1};
            1: field_vals[FIELD_INVOC] = {1'b0, cur_invoc ^ (63'd1 << $urandom_range(0, 62))};
            2: field_vals[FIELD_STATUS] = STATUS_MAX + 64'd1 + 64'($urandom_range(0, 3));
            3: field_vals[FIELD_STATUS] = 64'd0 - 64'($urandom_range(1, 3));
            4: field_vals[FIELD_CODE] = CODE_MAX + 64'd1 + 64'($urandom_range(0, 3));
            default: field_vals[FIELD_CODE] = 64'd0 - 64'($urandom_range(1, 3));
        endcase
    endfunction

    // Turns the nth separator after the tag into the other separator.
    function automatic void swap_terminator(input int nth);
        int seen;

        seen = 0;
        for (int i = TAG_BYTES; i < frame_bytes.size(); i++) begin
            if (frame_bytes[i] == CH_BAR || frame_bytes[i] == CH_NL) begin
                if (seen == nth) begin
                    frame_bytes[i] = (frame_bytes[i] == CH_BAR) ? CH_NL : CH_BAR;
                    return;
                end
                seen++;
            end
        end
    endfunction

    function automatic void cut_frame(input int keep);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_data_byte           <= value;
        i_frame_last          <= last;
        i_expected_lane       <= cur_lane;
        i_expected_invocation <= cur_invoc;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic send_with_text(input int f, input string s);
        fresh_frame();
        use_text[f]   = 1'b1;
        field_text[f] = s;
        build_frame();
        send_frame();
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Output side stalls in random bursts while idling is enabled.
    initial begin : output_stall
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("decimal_result_frame_parser_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int    start_bytes;
        int    pick;
        int    f;
        flaw_e kind;

        i_rst_n               <= 1'b0;
        i_valid               <= 1'b0;
        i_data_byte           <= '0;
        i_frame_last          <= 1'b0;
        i_expected_lane       <= '0;
        i_expected_invocation <= '0;
        cur_lane              = '0;
        cur_invoc             = 63'd1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // Clean frame with the smallest ids and the extreme field values.
        fresh_frame();
        cur_lane                 = 2'd0;
        cur_invoc                = 63'd1;
        field_vals[FIELD_LANE]   = 64'd0;
        field_vals[FIELD_INVOC]  = 64'd1;
        field_vals[FIELD_STATUS] = 64'd0;
        field_vals[FIELD_CODE]   = 64'd0;
        field_vals[3]            = 64'h7FFF_FFFF_FFFF_FFFF;
        field_vals[4]            = 64'h8000_0000_0000_0000;
        use_text[5]              = 1'b1;
        field_text[5]            = "-0";
        build_frame();
        send_frame();

        // Clean frame with the largest ids and the top of each checked range.
        fresh_frame();
        cur_lane                 = 2'd2;
        cur_invoc                = '1;
        field_vals[FIELD_LANE]   = 64'd2;
        field_vals[FIELD_INVOC]  = {1'b0, cur_invoc};
        field_vals[FIELD_STATUS] = STATUS_MAX;
        field_vals[FIELD_CODE]   = CODE_MAX;
        field_vals[7]            = 64'hFFFF_FFFF_FFFF_FFFF;
        field_zeros[8]           = 3;
        build_frame();
        send_frame();

        // Each value check failing on its own.
        for (int k = 0; k < 6; k++) begin
            fresh_frame();
            break_value_check(k);
            build_frame();
            send_frame();
        end

        // Tag errors, a frame ending inside the tag and a short frame.
        fresh_frame();
        build_frame();
        frame_bytes[4] = 8'h58;
        send_frame();
        fresh_frame();
        build_frame();
        frame_bytes[TAG_BYTES - 1] = CH_ZERO;
        send_frame();
        fresh_frame();
        build_frame();
        cut_frame(4);
        send_frame();
        fresh_frame();
        build_frame();
        cut_frame(9);
        send_frame();

        // Overflow, empty fields, misplaced minus and stray characters.
        send_with_text(3, "18446744073709551616");
        send_with_text(3, "18446744073709551615");
        send_with_text(4, "9223372036854775808");
        send_with_text(4, "-9223372036854775809");
        send_with_text(0, "");
        send_with_text(14, "-");
        send_with_text(6, "--1");
        send_with_text(7, "4-");
        send_with_text(8, "1a");
        send_with_text(9, "/");
        send_with_text(10, ":");
        send_with_text(NUM_FIELDS - 1, "-9223372036854775808");

        // Wrong terminators and a byte after the closing newline.
        fresh_frame();
        build_frame();
        swap_terminator(3);
        send_frame();
        fresh_frame();
        build_frame();
        swap_terminator(NUM_FIELDS - 1);
        send_frame();
        fresh_frame();
        build_frame();
        frame_bytes.push_back(CH_ZERO);
        send_frame();

        // Frame lengths one below the cap, at the cap, and past the counter range.
        for (int k = 0; k < 3; k++) begin
            fresh_frame();
            build_frame();
            field_zeros[5] = (k == 0 ? FRAME_CAP_DEF - 1 : k == 1 ? FRAME_CAP_DEF : HUGE_FRAME)
                             - frame_bytes.size();
            build_frame();
            send_frame();
        end

        wait_for_results();

        // Mostly well-formed frames, with damaged frames and noise mixed in.
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            fresh_frame();
            if ($urandom_range(0, 99) < 55) kind = FLAW_NONE;
            else kind = flaw_e'($urandom_range(1, FLAW_NOISE));
            f    = $urandom_range(0, NUM_FIELDS - 1);
            pick = $urandom_range(0, 3);
            case (kind)
                FLAW_EMPTY: begin
                    use_text[f]   = 1'b1;
                    field_text[f] = pick[0] ? "" : "-";
                end
                FLAW_MINUS: begin
                    use_text[f] = 1'b1;
                    case (pick)
                        0:       field_text[f] = "--5";
                        1:       field_text[f] = "7-";
                        2:       field_text[f] = "1-2";
                        default: field_text[f] = "-3-";
                    endcase
                end
                FLAW_CHAR: begin
                    use_text[f] = 1'b1;
                    case (pick)
                        0:       field_text[f] = "1a";
                        1:       field_text[f] = ":";
                        2:       field_text[f] = "/9";
                        default: field_text[f] = " 5";
                    endcase
                end
                FLAW_OVERFLOW: begin
                    use_text[f] = 1'b1;
                    case (pick)
                        0:       field_text[f] = "99999999999999999999";
                        1:       field_text[f] = "18446744073709551616";
                        2:       field_text[f] = "9223372036854775808";
                        default: field_text[f] = "-9223372036854775809";
                    endcase
                end
                FLAW_CHECK: break_value_check($urandom_range(0, 5));
                default: ;
            endcase
            build_frame();
            case (kind)
                FLAW_BYTE:
                    frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                FLAW_CUT:   cut_frame($urandom_range(1, frame_bytes.size() - 1));
                FLAW_TRAIL: repeat ($urandom_range(1, 3))
                                frame_bytes.push_back(8'($urandom_range(0, 255)));
                FLAW_TERM:  swap_terminator(f);
                FLAW_NOISE: begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 12))
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            send_frame();
            if ($urandom_range(0, 7) == 0) wait_for_results();
        end

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        repeat (2) begin
            fresh_frame();
            build_frame();
            send_frame();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("decimal_result_frame_parser_core regression: pass");
        end else begin
            $display("decimal_result_frame_parser_core regression: fail");
        end
        $finish;
    end

endmodule
